[rtl/hierarchical_page_table_walker_defines.svh]
// Assertion macros for the page-table walker RTL.
`ifndef HIERARCHICAL_PAGE_TABLE_WALKER_DEFINES_SVH
`define HIERARCHICAL_PAGE_TABLE_WALKER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define HPTW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define HPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hptw_pkg.sv]
package hptw_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

    // Request item.
    typedef struct packed {
        logic               operation;
        logic [15:0]        virtual_address;
        logic signed [31:0] write_value;
    } req_t;

    // Result item.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         physical_address;
    } rsp_t;

    // Kind of frame picked on a page fault.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_UNUSED = 2'd2,
        KIND_EVICT  = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_WALK_RD = 13'b0000000000010,
        ST_WALK_EV = 13'b0000000000100,
        ST_SCAN_RD = 13'b0000000001000,
        ST_SCAN_EV = 13'b0000000010000,
        ST_PICK    = 13'b0000000100000,
        ST_COPY    = 13'b0000001000000,
        ST_UNLINK  = 13'b0000010000000,
        ST_FILL    = 13'b0000100000000,
        ST_LINK    = 13'b0001000000000,
        ST_ACC_RD  = 13'b0010000000000,
        ST_ACC_EV  = 13'b0100000000000,
        ST_RESP    = 13'b1000000000000
    } state_t;

endpackage

[rtl/hptw_frame_mem.sv]
module hptw_frame_mem #(
    parameter int ADDR_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [DEPTH-1:0]     valid_reg;
    logic                 rd_valid_reg;

    // Storage array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // One valid bit per word; a word never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

[rtl/hptw_swap_mem.sv]
module hptw_swap_mem #(
    parameter int ADDR_BITS = 12,
    parameter int ROW_BITS  = 4,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam int ROWS  = 1 << (ADDR_BITS - ROW_BITS);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [ROWS-1:0]      valid_reg;
    logic                 rd_valid_reg;

    // Storage array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // One valid bit per page; write pages whole before reading; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr[ADDR_BITS-1:ROW_BITS]] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr[ADDR_BITS-1:ROW_BITS]];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

[rtl/hierarchical_page_table_walker.sv]
// With every entry present an item walks each level in a read and an evaluate state, then a
// write ends in the access read state and a read adds an access evaluate state; the response
// state holds while the output stalls. A page fault adds per level a tree scan (a read and an
// evaluate per table entry, a closing read per table visited, at most FRAME_COUNT*2^OFFSET_BITS
// entries), a pick, an unlink when a frame is taken from the tree, a page copy (eviction only),
// a page fill and a link. Throughput: one item at a time. Reset: both memories read as zero.
`include "hierarchical_page_table_walker_defines.svh"

module hierarchical_page_table_walker #(
    parameter int OFFSET_BITS  = 4,
    parameter int TABLE_LEVELS = 2,
    parameter int FRAME_COUNT  = 16,
    parameter int WORD_BITS    = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  hptw_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output hptw_pkg::rsp_t   rsp
);

    localparam int OB   = OFFSET_BITS;
    localparam int L    = TABLE_LEVELS;
    localparam int P    = 1 << OB;
    localparam int FNW  = $clog2(FRAME_COUNT);
    localparam int FAW  = FNW + OB;
    localparam int PGB  = OB * L;
    localparam int VB   = PGB + OB;
    localparam int DW   = $clog2(L + 1);
    localparam int CW   = OB + 1;
    localparam int DSTW = PGB + 1;

    hptw_pkg::state_t state_reg, state_next;

    logic                 op_reg, op_next;
    logic [15:0]          va_reg, va_next;
    logic [WORD_BITS-1:0] wv_reg, wv_next;
    logic [DW-1:0]        lvl_reg, lvl_next;
    logic [FNW-1:0]       cur_reg, cur_next;
    logic [FNW-1:0]       path_reg [0:L];
    logic [FNW-1:0]       path_next [0:L];

    // Walk stack for the tree scan.
    logic [DW-1:0]        d_reg, d_next;
    logic [FNW-1:0]       sf_reg [0:L];
    logic [FNW-1:0]       sf_next [0:L];
    logic [CW-1:0]        si_reg [0:L];
    logic [CW-1:0]        si_next [0:L];
    logic [PGB-1:0]       sp_reg [0:L];
    logic [PGB-1:0]       sp_next [0:L];
    logic [FNW-1:0]       spf_reg [0:L];
    logic [FNW-1:0]       spf_next [0:L];
    logic [OB-1:0]        spi_reg [0:L];
    logic [OB-1:0]        spi_next [0:L];
    logic [L:0]           se_reg, se_next;

    // Current frame choice.
    hptw_pkg::kind_t      kind_reg, kind_next;
    logic [FNW-1:0]       cf_reg, cf_next;
    logic [PGB-1:0]       cpage_reg, cpage_next;
    logic [FNW-1:0]       cpf_reg, cpf_next;
    logic [OB-1:0]        cpi_reg, cpi_next;
    logic [DSTW-1:0]      cdist_reg, cdist_next;
    logic [FNW-1:0]       maxf_reg, maxf_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    hptw_pkg::rsp_t       pend_reg, pend_next;
    hptw_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Memory ports.
    logic [FAW-1:0]       fm_rd_addr, fm_wr_addr;
    logic [WORD_BITS-1:0] fm_rd_data, fm_wr_data;
    logic                 fm_wr_en;
    logic [VB-1:0]        sw_rd_addr, sw_wr_addr;
    logic [WORD_BITS-1:0] sw_rd_data, sw_wr_data;
    logic                 sw_wr_en;

    // Helpers.
    logic [OB-1:0]        idx;
    logic [PGB-1:0]       target;
    logic                 entry_nz;
    logic [FNW-1:0]       entry_frame;
    logic                 last_lvl;
    logic                 out_of_range;
    logic [FAW-1:0]       acc_addr;

    hptw_frame_mem #(
        .ADDR_BITS (FAW),
        .WORD_BITS (WORD_BITS)
    ) u_frame_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (fm_rd_addr),
        .rd_data (fm_rd_data),
        .wr_en   (fm_wr_en),
        .wr_addr (fm_wr_addr),
        .wr_data (fm_wr_data)
    );

    hptw_swap_mem #(
        .ADDR_BITS (VB),
        .ROW_BITS  (OB),
        .WORD_BITS (WORD_BITS)
    ) u_swap_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (sw_rd_addr),
        .rd_data (sw_rd_data),
        .wr_en   (sw_wr_en),
        .wr_addr (sw_wr_addr),
        .wr_data (sw_wr_data)
    );

    // Address fields of the current item.
    assign idx          = OB'(va_reg >> (OB * (L - int'(lvl_reg))));
    assign target       = PGB'(va_reg >> OB);
    assign last_lvl     = (lvl_reg == DW'(L - 1));
    assign out_of_range = ((req.virtual_address >> VB) != 16'd0);
    assign acc_addr     = {cur_reg, va_reg[OB-1:0]};

    // A table entry counts only if it names an existing frame other than frame zero, the root.
    assign entry_nz    = (fm_rd_data < WORD_BITS'(FRAME_COUNT)) && (fm_rd_data != '0);
    assign entry_frame = entry_nz ? FNW'(fm_rd_data) : '0;

    assign req_stall = (state_reg != hptw_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer.
    always_comb
    begin
        logic                  on_path;
        logic [PGB-1:0]        child;
        logic [PGB-1:0]        diff;
        logic [DSTW-1:0]       wrap;
        logic [DSTW-1:0]       leaf_dist;
        logic [OB-1:0]         ei;

        state_next     = state_reg;
        op_next        = op_reg;
        va_next        = va_reg;
        wv_next        = wv_reg;
        lvl_next       = lvl_reg;
        cur_next       = cur_reg;
        path_next      = path_reg;
        d_next         = d_reg;
        sf_next        = sf_reg;
        si_next        = si_reg;
        sp_next        = sp_reg;
        spf_next       = spf_reg;
        spi_next       = spi_reg;
        se_next        = se_reg;
        kind_next      = kind_reg;
        cf_next        = cf_reg;
        cpage_next     = cpage_reg;
        cpf_next       = cpf_reg;
        cpi_next       = cpi_reg;
        cdist_next     = cdist_reg;
        maxf_next      = maxf_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        fm_rd_addr = {cur_reg, idx};
        fm_wr_en   = 1'b0;
        fm_wr_addr = '0;
        fm_wr_data = '0;
        sw_rd_addr = {target, cnt_reg[OB-1:0]};
        sw_wr_en   = 1'b0;
        sw_wr_addr = '0;
        sw_wr_data = '0;

        // Is the frame on top of the stack part of the current walk?
        on_path = 1'b0;
        for (int k = 0; k <= L; k++)
        begin
            if ((DW'(k) <= lvl_reg) && (path_reg[k] == sf_reg[d_reg]))
            begin
                on_path = 1'b1;
            end
        end

        // Cyclic distance between the target page and the scanned leaf.
        ei        = si_reg[d_reg][OB-1:0];
        child     = PGB'({sp_reg[d_reg], ei});
        diff      = (target > child) ? (target - child) : (child - target);
        wrap      = (DSTW'(1) << PGB) - DSTW'(diff);
        leaf_dist = (DSTW'(diff) < wrap) ? DSTW'(diff) : wrap;

        unique case (state_reg)
            hptw_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.operation;
                    va_next  = req.virtual_address;
                    wv_next  = WORD_BITS'(req.write_value);
                    lvl_next = '0;
                    cur_next = '0;
                    if (out_of_range)
                    begin
                        pend_next  = '{status: hptw_pkg::STATUS_RANGE, read_value: '0,
                                       physical_address: '0};
                        state_next = hptw_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = hptw_pkg::ST_WALK_RD;
                    end
                end
            end

            hptw_pkg::ST_WALK_RD:
            begin
                path_next[lvl_reg] = cur_reg;
                state_next         = hptw_pkg::ST_WALK_EV;
            end

            hptw_pkg::ST_WALK_EV:
            begin
                if (entry_nz)
                begin
                    cur_next = entry_frame;
                    if (last_lvl)
                    begin
                        state_next = hptw_pkg::ST_ACC_RD;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = hptw_pkg::ST_WALK_RD;
                    end
                end
                else
                begin
                    // Page fault: start the scan at the root.
                    d_next      = '0;
                    sf_next[0]  = '0;
                    si_next[0]  = '0;
                    sp_next[0]  = '0;
                    spf_next[0] = '0;
                    spi_next[0] = '0;
                    se_next[0]  = 1'b1;
                    kind_next   = hptw_pkg::KIND_NONE;
                    maxf_next   = '0;
                    state_next  = hptw_pkg::ST_SCAN_RD;
                end
            end

            hptw_pkg::ST_SCAN_RD:
            begin
                fm_rd_addr = {sf_reg[d_reg], ei};
                if (!si_reg[d_reg][OB])
                begin
                    state_next = hptw_pkg::ST_SCAN_EV;
                end
                else
                begin
                    // Table finished: an empty one off the walk is the best choice.
                    if (se_reg[d_reg] && (d_reg != '0) && (kind_reg != hptw_pkg::KIND_EMPTY)
                        && !on_path)
                    begin
                        kind_next = hptw_pkg::KIND_EMPTY;
                        cf_next   = sf_reg[d_reg];
                        cpf_next  = spf_reg[d_reg];
                        cpi_next  = spi_reg[d_reg];
                    end
                    if (d_reg == '0)
                    begin
                        state_next = hptw_pkg::ST_PICK;
                    end
                    else
                    begin
                        d_next = d_reg - 1'b1;
                    end
                end
            end

            hptw_pkg::ST_SCAN_EV:
            begin
                si_next[d_reg] = si_reg[d_reg] + 1'b1;
                state_next     = hptw_pkg::ST_SCAN_RD;
                if (entry_nz)
                begin
                    se_next[d_reg] = 1'b0;
                    if (entry_frame > maxf_reg)
                    begin
                        maxf_next = entry_frame;
                    end
                    if (d_reg == DW'(L - 1))
                    begin
                        // Data page: keep the farthest one, first found on ties.
                        if ((kind_reg != hptw_pkg::KIND_EMPTY)
                            && ((kind_reg != hptw_pkg::KIND_EVICT) || (leaf_dist > cdist_reg)))
                        begin
                            kind_next  = hptw_pkg::KIND_EVICT;
                            cf_next    = entry_frame;
                            cpage_next = child;
                            cpf_next   = sf_reg[d_reg];
                            cpi_next   = ei;
                            cdist_next = leaf_dist;
                        end
                    end
                    else
                    begin
                        d_next                  = d_reg + 1'b1;
                        sf_next[d_reg + 1'b1]  = entry_frame;
                        si_next[d_reg + 1'b1]  = '0;
                        sp_next[d_reg + 1'b1]  = child;
                        spf_next[d_reg + 1'b1] = sf_reg[d_reg];
                        spi_next[d_reg + 1'b1] = ei;
                        se_next[d_reg + 1'b1]  = 1'b1;
                    end
                end
            end

            hptw_pkg::ST_PICK:
            begin
                cnt_next = '0;
                if ((kind_reg != hptw_pkg::KIND_EMPTY)
                    && (((FNW + 1)'(maxf_reg) + 1'b1) < (FNW + 1)'(FRAME_COUNT)))
                begin
                    kind_next  = hptw_pkg::KIND_UNUSED;
                    cf_next    = maxf_reg + 1'b1;
                    state_next = hptw_pkg::ST_FILL;
                end
                else
                begin
                    priority case (kind_reg)
                        hptw_pkg::KIND_EVICT:
                        begin
                            state_next = hptw_pkg::ST_COPY;
                        end
                        hptw_pkg::KIND_EMPTY:
                        begin
                            state_next = hptw_pkg::ST_UNLINK;
                        end
                        default:
                        begin
                            pend_next  = '{status: hptw_pkg::STATUS_NO_FRAME, read_value: '0,
                                           physical_address: '0};
                            state_next = hptw_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            hptw_pkg::ST_COPY:
            begin
                // Evicted page goes to swap, one word a cycle, each word written in the cycle after it is read.
                fm_rd_addr = {cf_reg, cnt_reg[OB-1:0]};
                if (cnt_reg != '0)
                begin
                    sw_wr_en   = 1'b1;
                    sw_wr_addr = {cpage_reg, OB'(cnt_reg - 1'b1)};
                    sw_wr_data = fm_rd_data;
                end
                if (cnt_reg[OB])
                begin
                    state_next = hptw_pkg::ST_UNLINK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            hptw_pkg::ST_UNLINK:
            begin
                fm_wr_en   = 1'b1;
                fm_wr_addr = {cpf_reg, cpi_reg};
                fm_wr_data = '0;
                cnt_next   = '0;
                state_next = hptw_pkg::ST_FILL;
            end

            hptw_pkg::ST_FILL:
            begin
                // New table is cleared; new data page is restored from swap.
                if (cnt_reg != '0)
                begin
                    fm_wr_en   = 1'b1;
                    fm_wr_addr = {cf_reg, OB'(cnt_reg - 1'b1)};
                    fm_wr_data = last_lvl ? sw_rd_data : '0;
                end
                if (cnt_reg[OB])
                begin
                    state_next = hptw_pkg::ST_LINK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            hptw_pkg::ST_LINK:
            begin
                fm_wr_en   = 1'b1;
                fm_wr_addr = {cur_reg, idx};
                fm_wr_data = WORD_BITS'(cf_reg);
                cur_next   = cf_reg;
                if (last_lvl)
                begin
                    state_next = hptw_pkg::ST_ACC_RD;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = hptw_pkg::ST_WALK_RD;
                end
            end

            hptw_pkg::ST_ACC_RD:
            begin
                fm_rd_addr = acc_addr;
                if (op_reg)
                begin
                    fm_wr_en   = 1'b1;
                    fm_wr_addr = acc_addr;
                    fm_wr_data = wv_reg;
                    pend_next  = '{status: hptw_pkg::STATUS_DONE, read_value: '0,
                                   physical_address: 8'(acc_addr)};
                    state_next = hptw_pkg::ST_RESP;
                end
                else
                begin
                    state_next = hptw_pkg::ST_ACC_EV;
                end
            end

            hptw_pkg::ST_ACC_EV:
            begin
                pend_next  = '{status: hptw_pkg::STATUS_DONE,
                               read_value: 32'(signed'(fm_rd_data)),
                               physical_address: 8'(acc_addr)};
                state_next = hptw_pkg::ST_RESP;
            end

            hptw_pkg::ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = hptw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hptw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hptw_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        va_reg    <= va_next;
        wv_reg    <= wv_next;
        lvl_reg   <= lvl_next;
        cur_reg   <= cur_next;
        path_reg  <= path_next;
        d_reg     <= d_next;
        sf_reg    <= sf_next;
        si_reg    <= si_next;
        sp_reg    <= sp_next;
        spf_reg   <= spf_next;
        spi_reg   <= spi_next;
        se_reg    <= se_next;
        kind_reg  <= kind_next;
        cf_reg    <= cf_next;
        cpage_reg <= cpage_next;
        cpf_reg   <= cpf_next;
        cpi_reg   <= cpi_next;
        cdist_reg <= cdist_next;
        maxf_reg  <= maxf_next;
        cnt_reg   <= cnt_next;
        pend_reg  <= pend_next;
        rsp_reg   <= rsp_next;
    end

    // Checks on the sequencer.
    `HPTW_ASSERT_NEXT(a_range_resp, req_valid && !req_stall && out_of_range, state_reg == hptw_pkg::ST_RESP && pend_reg.status == hptw_pkg::STATUS_RANGE, "out-of-range item not answered at once")
    `HPTW_ASSERT_SAME(a_scan_ro, state_reg == hptw_pkg::ST_SCAN_RD || state_reg == hptw_pkg::ST_SCAN_EV, !fm_wr_en && !sw_wr_en, "memory written during tree scan")
    `HPTW_ASSERT_SAME(a_rsp_src, $rose(rsp_valid_reg), $past(state_reg == hptw_pkg::ST_RESP), "result raised outside response state")
    `HPTW_ASSERT_SAME(a_depth, state_reg == hptw_pkg::ST_SCAN_EV, d_reg < DW'(L), "scan stack overflow")

endmodule
